// ===== rtl/lnfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lnfs_pkg;

    // operation codes of an input item
    localparam logic [2:0] OP_COMMAND   = 3'd0;
    localparam logic [2:0] OP_CHARACTER = 3'd1;
    localparam logic [2:0] OP_CURSOR    = 3'd2;
    localparam logic [2:0] OP_CHAR_AT   = 3'd3;
    localparam logic [2:0] OP_INIT      = 3'd4;

    // init sequence steps
    localparam logic [2:0] INIT_STEP_RAW_A   = 3'd0;
    localparam logic [2:0] INIT_STEP_RAW_B   = 3'd1;
    localparam logic [2:0] INIT_STEP_RAW_C   = 3'd2;
    localparam logic [2:0] INIT_STEP_RAW_4B  = 3'd3;
    localparam logic [2:0] INIT_STEP_FUNC    = 3'd4;
    localparam logic [2:0] INIT_STEP_DISPLAY = 3'd5;
    localparam logic [2:0] INIT_STEP_ENTRY   = 3'd6;

    // LCD constants
    localparam logic [7:0] INIT_NIBBLE      = 8'h03;
    localparam logic [7:0] INIT_4BIT_NIBBLE = 8'h02;
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;

    // cursor row bases
    localparam logic [2:0] ROW_TWO   = 3'd2;
    localparam logic [2:0] ROW_THREE = 3'd3;
    localparam logic [2:0] ROW_FOUR  = 3'd4;
    localparam logic [7:0] BASE_ROW_TWO   = 8'd191;
    localparam logic [7:0] BASE_ROW_THREE = 8'd147;
    localparam logic [7:0] BASE_ROW_FOUR  = 8'd211;
    localparam logic [7:0] BASE_DEFAULT   = 8'd127;

    // waits in microseconds
    localparam logic [12:0] WAIT_NIBBLE_US     = 13'd100;
    localparam logic [12:0] WAIT_CMD_EXTRA_US  = 13'd5000;
    localparam logic [12:0] WAIT_INIT_LONG_US  = 13'd4500;
    localparam logic [12:0] WAIT_INIT_SHORT_US = 13'd150;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        EXTRA_NONE,
        EXTRA_CMD,
        EXTRA_INIT_LONG,
        EXTRA_INIT_SHORT
    } extra_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] byte_value;
        logic [2:0] row;
        logic [7:0] column;
    } in_item_t;

    typedef struct packed {
        logic        enable_bit;
        logic        register_select;
        logic [3:0]  data_nibble;
        logic [12:0] wait_after_us;
        logic        last_frame;
    } out_frame_t;

    // one unit of back-end work: a whole byte or a single raw nibble
    typedef struct packed {
        logic       raw;
        logic       rs;
        logic [7:0] value;
        extra_t     extra;
        logic       last;
    } seg_t;

    function automatic logic [7:0] row_base(input logic [2:0] row);
        logic [7:0] base;
        unique case (row)
            ROW_TWO:   base = BASE_ROW_TWO;
            ROW_THREE: base = BASE_ROW_THREE;
            ROW_FOUR:  base = BASE_ROW_FOUR;
            default:   base = BASE_DEFAULT;
        endcase
        return base;
    endfunction

    function automatic seg_t make_seg(input logic raw, input logic rs, input logic [7:0] value,
                                      input extra_t extra, input logic last);
        seg_t s;
        s.raw   = raw;
        s.rs    = rs;
        s.value = value;
        s.extra = extra;
        s.last  = last;
        return s;
    endfunction

    // segment number step of an operation
    function automatic seg_t seg_of(input logic [2:0] op, input logic [2:0] step,
                                    input logic [7:0] b, input logic [7:0] addr);
        seg_t s;
        unique case (op)
            OP_COMMAND:   s = make_seg(1'b0, 1'b0, b, EXTRA_CMD, 1'b1);
            OP_CHARACTER: s = make_seg(1'b0, 1'b1, b, EXTRA_NONE, 1'b1);
            OP_CURSOR:    s = make_seg(1'b0, 1'b0, addr, EXTRA_CMD, 1'b1);
            OP_CHAR_AT:
            begin
                if (step == 3'd0)
                    s = make_seg(1'b0, 1'b0, addr, EXTRA_CMD, 1'b0);
                else
                    s = make_seg(1'b0, 1'b1, b, EXTRA_NONE, 1'b1);
            end
            OP_INIT:
            begin
                unique case (step)
                    INIT_STEP_RAW_A:
                        s = make_seg(1'b1, 1'b0, INIT_NIBBLE, EXTRA_INIT_LONG, 1'b0);
                    INIT_STEP_RAW_B:
                        s = make_seg(1'b1, 1'b0, INIT_NIBBLE, EXTRA_INIT_LONG, 1'b0);
                    INIT_STEP_RAW_C:
                        s = make_seg(1'b1, 1'b0, INIT_NIBBLE, EXTRA_INIT_SHORT, 1'b0);
                    INIT_STEP_RAW_4B:
                        s = make_seg(1'b1, 1'b0, INIT_4BIT_NIBBLE, EXTRA_NONE, 1'b0);
                    INIT_STEP_FUNC:
                        s = make_seg(1'b0, 1'b0, CMD_FUNCTION_SET, EXTRA_CMD, 1'b0);
                    INIT_STEP_DISPLAY:
                        s = make_seg(1'b0, 1'b0, CMD_DISPLAY_ON, EXTRA_CMD, 1'b0);
                    default:
                        s = make_seg(1'b0, 1'b0, CMD_ENTRY_MODE, EXTRA_CMD, 1'b1);
                endcase
            end
            default:      s = make_seg(1'b0, 1'b0, b, EXTRA_CMD, 1'b1);
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lnfs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lnfs_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lnfs_pkg::in_item_t item,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              q_full,
    output logic                   q_push,
    output lnfs_pkg::seg_t         q_data
);

    logic       busy_reg, busy_next;
    logic [2:0] step_reg, step_next;
    logic [2:0] op_reg, op_next;
    logic [7:0] byte_reg, byte_next;
    logic [7:0] addr_reg, addr_next;
    logic       accept;
    logic       op_valid;

    assign full     = busy_reg;
    assign accept   = push && !busy_reg;
    assign op_valid = (item.operation <= lnfs_pkg::OP_INIT);

    // segment for the current step
    assign q_data = lnfs_pkg::seg_of(op_reg, step_reg, byte_reg, addr_reg);
    assign q_push = busy_reg && !q_full;

    // item capture and segment issue
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        op_next   = op_reg;
        byte_next = byte_reg;
        addr_next = addr_reg;
        if (accept)
        begin
            // unused operation codes make no frames and are dropped
            busy_next = op_valid;
            step_next = 3'd0;
            op_next   = item.operation;
            byte_next = item.byte_value;
            addr_next = lnfs_pkg::row_base(item.row) + item.column;
        end
        else if (q_push)
        begin
            if (q_data.last)
                busy_next = 1'b0;
            else
                step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        byte_reg <= byte_next;
        addr_reg <= addr_next;
    end

endmodule

`default_nettype wire

// ===== rtl/lnfs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lnfs_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire lnfs_pkg::seg_t wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output lnfs_pkg::seg_t      rd_data,
    output logic                empty
);

    lnfs_pkg::seg_t                      mem_reg [lnfs_pkg::QUEUE_DEPTH];
    logic [lnfs_pkg::QUEUE_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [lnfs_pkg::QUEUE_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [lnfs_pkg::QUEUE_AW:0]         count_reg, count_next;
    logic                                do_wr, do_rd;

    assign full    = (count_reg == (lnfs_pkg::QUEUE_AW+1)'(lnfs_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = wr_ptr_reg + lnfs_pkg::QUEUE_AW'(1);
        if (do_rd)
            rd_ptr_next = rd_ptr_reg + lnfs_pkg::QUEUE_AW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + (lnfs_pkg::QUEUE_AW+1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (lnfs_pkg::QUEUE_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== rtl/lnfs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lnfs_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire lnfs_pkg::seg_t q_data,
    output logic                q_pop,
    output lnfs_pkg::out_frame_t result,
    output logic                empty,
    input  wire logic           pop
);

    lnfs_pkg::seg_t       seg_reg, seg_next;
    logic                 seg_valid_reg, seg_valid_next;
    logic [1:0]           idx_reg, idx_next;
    lnfs_pkg::out_frame_t out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    lnfs_pkg::out_frame_t frame;
    logic                 final_frame;
    logic                 out_free;
    logic                 advance;
    logic                 seg_done;
    logic [12:0]          extra_us;

    // final frame of the segment: second frame of a raw nibble, fourth of a byte
    assign final_frame = seg_reg.raw ? (idx_reg == 2'd1) : (idx_reg == 2'd3);
    assign out_free    = !out_valid_reg || pop;
    assign advance     = seg_valid_reg && out_free;
    assign seg_done    = advance && final_frame;
    assign q_pop       = (!seg_valid_reg || seg_done) && !q_empty;

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    // extra wait after the last nibble of the segment
    always_comb
    begin
        unique case (seg_reg.extra)
            lnfs_pkg::EXTRA_NONE:       extra_us = '0;
            lnfs_pkg::EXTRA_CMD:        extra_us = lnfs_pkg::WAIT_CMD_EXTRA_US;
            lnfs_pkg::EXTRA_INIT_LONG:  extra_us = lnfs_pkg::WAIT_INIT_LONG_US;
            lnfs_pkg::EXTRA_INIT_SHORT: extra_us = lnfs_pkg::WAIT_INIT_SHORT_US;
            default:                    extra_us = '0;
        endcase
    end

    // frame build: E high on even frames, high nibble first for a byte
    always_comb
    begin
        frame.enable_bit      = !idx_reg[0];
        frame.register_select = seg_reg.rs;
        if (seg_reg.raw || idx_reg[1])
            frame.data_nibble = seg_reg.value[3:0];
        else
            frame.data_nibble = seg_reg.value[7:4];
        if (!idx_reg[0])
            frame.wait_after_us = '0;
        else if (final_frame)
            frame.wait_after_us = lnfs_pkg::WAIT_NIBBLE_US + extra_us;
        else
            frame.wait_after_us = lnfs_pkg::WAIT_NIBBLE_US;
        frame.last_frame = seg_reg.last && final_frame;
    end

    // segment and output register control
    always_comb
    begin
        seg_next       = seg_reg;
        seg_valid_next = seg_valid_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            seg_next       = q_data;
            seg_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (seg_done)
            seg_valid_next = 1'b0;
        else if (advance)
            idx_next = idx_reg + 2'd1;
        if (advance)
        begin
            out_next       = frame;
            out_valid_next = 1'b1;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_valid_reg <= seg_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== rtl/lcd_nibble_shift_frame_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Turns LCD operations (command, character, cursor set, character at position,
// init) into shift-register frames for a 4-bit character LCD, one frame per
// result transfer. A front end takes an item and breaks it into byte or raw
// nibble segments, one per cycle while the queue has room, into a four-entry
// queue; a back end turns each segment into frames, one per cycle while the
// output register is free, into that register. The back end sets the rate:
// command, character and cursor set make 4 frames, character at position 8
// and init 20, all passing the front end, queue, segment and output registers.
// A new item is taken once the front end has queued every segment of the
// previous one. Codes 5 to 7 are taken and make no frames.
module lcd_nibble_shift_frame_sequencer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lnfs_pkg::in_item_t item,
    input  wire logic               push,
    output logic                    full,
    output lnfs_pkg::out_frame_t    result,
    output logic                    empty,
    input  wire logic               pop
);

    lnfs_pkg::seg_t fq_data;
    lnfs_pkg::seg_t qb_data;
    logic           fq_push;
    logic           fq_full;
    logic           qb_pop;
    logic           qb_empty;

    // item capture and segment issue
    lnfs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .push   (push),
        .full   (full),
        .q_full (fq_full),
        .q_push (fq_push),
        .q_data (fq_data)
    );

    // segment queue between the two ends
    lnfs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_data),
        .full    (fq_full),
        .rd_en   (qb_pop),
        .rd_data (qb_data),
        .empty   (qb_empty)
    );

    // frame generation
    lnfs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (qb_empty),
        .q_data  (qb_data),
        .q_pop   (qb_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

`default_nettype wire

// ===== rtl/lnfs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lnfs_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lnfs_pkg::out_frame_t result,
    input  wire logic                 empty,
    input  wire logic                 pop
);

    // a waiting result holds until transferred
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while waiting");

    // E-high frame is followed at once by its E-low frame with the same lines
    a_nibble_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result.enable_bit) |=>
        (!empty && !result.enable_bit
         && result.data_nibble == $past(result.data_nibble)
         && result.register_select == $past(result.register_select)))
        else $error("E-high frame not followed by its E-low frame");

    // E-high frames have no wait, E-low frames wait at least one nibble time
    a_wait_shape: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.enable_bit ? (result.wait_after_us == 13'd0)
                                      : (result.wait_after_us >= 13'd100)))
        else $error("frame wait does not match E line");

    // the last frame of an item is an E-low frame
    a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.last_frame) |-> !result.enable_bit)
        else $error("last frame with E high");

endmodule

bind lcd_nibble_shift_frame_sequencer lnfs_checker u_lnfs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .result (result),
    .empty  (empty),
    .pop    (pop)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // spare operation codes, taken by the block but producing no frames
    localparam logic [2:0] OP_FIRST_SPARE = 3'd5;
    localparam logic [2:0] OP_LAST_SPARE  = 3'd7;

    // waits in microseconds
    localparam logic [12:0] NIBBLE_WAIT      = 13'd100;
    localparam logic [12:0] CMD_SETTLE       = 13'd5000;
    localparam logic [12:0] INIT_SETTLE_LONG = 13'd4500;
    localparam logic [12:0] INIT_SETTLE_MID  = 13'd150;
    localparam logic [12:0] NO_SETTLE        = 13'd0;

    // lcd bytes and nibbles of the power-on sequence
    localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIBBLE  = 4'h2;
    localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;

    // ddram base address per row
    localparam logic [7:0] ROW2_BASE    = 8'd191;
    localparam logic [7:0] ROW3_BASE    = 8'd147;
    localparam logic [7:0] ROW4_BASE    = 8'd211;
    localparam logic [7:0] OTHER_BASE   = 8'd127;

    localparam int IDLE_PERCENT   = 38;
    localparam int RECV_HOLD_LEN  = 300;
    localparam int STALL_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_PRINTED    = 50;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    lnfs_pkg::in_item_t   item = '0;
    logic                 push = 1'b0;
    logic                 full;
    lnfs_pkg::out_frame_t result;
    logic                 empty;
    logic                 pop = 1'b0;

    lnfs_pkg::in_item_t   pending_items[$];
    lnfs_pkg::out_frame_t expected_frames[$];

    int  error_count = 0;
    int  frames_seen = 0;
    int  stall_cycles = 0;
    int  hold_token = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    bit  send_steady = 1'b0;
    bit  recv_steady = 1'b0;

    lcd_nibble_shift_frame_sequencer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .push   (push),
        .full   (full),
        .result (result),
        .empty  (empty),
        .pop    (pop)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic bit rests(input bit steady);
        return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    function automatic logic [7:0] cursor_addr(input logic [2:0] row, input logic [7:0] col);
        logic [7:0] base;
        case (row)
            3'd2:    base = ROW2_BASE;
            3'd3:    base = ROW3_BASE;
            3'd4:    base = ROW4_BASE;
            default: base = OTHER_BASE;
        endcase
        return base + col;
    endfunction

    // one nibble: E high frame, then E low frame carrying the wait
    task automatic add_nibble(input logic rs, input logic [3:0] d, input logic [12:0] extra);
        lnfs_pkg::out_frame_t f;
        f.enable_bit      = 1'b1;
        f.register_select = rs;
        f.data_nibble     = d;
        f.wait_after_us   = NO_SETTLE;
        f.last_frame      = 1'b0;
        expected_frames.push_back(f);
        f.enable_bit      = 1'b0;
        f.wait_after_us   = NIBBLE_WAIT + extra;
        expected_frames.push_back(f);
    endtask

    // whole byte, high nibble first
    task automatic add_byte(input logic rs, input logic [7:0] b, input logic [12:0] extra);
        add_nibble(rs, b[7:4], NO_SETTLE);
        add_nibble(rs, b[3:0], extra);
    endtask

    // frames that one accepted item must produce
    task automatic predict_frames(input lnfs_pkg::in_item_t it);
        lnfs_pkg::out_frame_t tail;
        logic [7:0]           addr;
        bit                   any;
        addr = cursor_addr(it.row, it.column);
        any  = 1'b1;
        case (it.operation)
            lnfs_pkg::OP_COMMAND:   add_byte(1'b0, it.byte_value, CMD_SETTLE);
            lnfs_pkg::OP_CHARACTER: add_byte(1'b1, it.byte_value, NO_SETTLE);
            lnfs_pkg::OP_CURSOR:    add_byte(1'b0, addr, CMD_SETTLE);
            lnfs_pkg::OP_CHAR_AT:
            begin
                add_byte(1'b0, addr, CMD_SETTLE);
                add_byte(1'b1, it.byte_value, NO_SETTLE);
            end
            lnfs_pkg::OP_INIT:
            begin
                add_nibble(1'b0, WAKE_NIBBLE, INIT_SETTLE_LONG);
                add_nibble(1'b0, WAKE_NIBBLE, INIT_SETTLE_LONG);
                add_nibble(1'b0, WAKE_NIBBLE, INIT_SETTLE_MID);
                add_nibble(1'b0, FOUR_BIT_NIBBLE, NO_SETTLE);
                add_byte(1'b0, LCD_FUNCTION_SET, CMD_SETTLE);
                add_byte(1'b0, LCD_DISPLAY_ON, CMD_SETTLE);
                add_byte(1'b0, LCD_ENTRY_MODE, CMD_SETTLE);
            end
            default:      any = 1'b0;
        endcase
        // flag the final frame of the item
        if (any)
        begin
            tail = expected_frames.pop_back();
            tail.last_frame = 1'b1;
            expected_frames.push_back(tail);
        end
    endtask

    task automatic check_frame(input lnfs_pkg::out_frame_t got);
        lnfs_pkg::out_frame_t want;
        if (expected_frames.size() == 0)
        begin
            report_mismatch($sformatf("frame %0d arrived with none expected (%h)",
                                      frames_seen, got));
        end
        else
        begin
            want = expected_frames.pop_front();
            if (got.enable_bit !== want.enable_bit)
                report_mismatch($sformatf("frame %0d enable_bit got %0b want %0b",
                                          frames_seen, got.enable_bit, want.enable_bit));
            if (got.register_select !== want.register_select)
                report_mismatch($sformatf("frame %0d register_select got %0b want %0b",
                                          frames_seen, got.register_select,
                                          want.register_select));
            if (got.data_nibble !== want.data_nibble)
                report_mismatch($sformatf("frame %0d data_nibble got %h want %h",
                                          frames_seen, got.data_nibble, want.data_nibble));
            if (got.wait_after_us !== want.wait_after_us)
                report_mismatch($sformatf("frame %0d wait_after_us got %0d want %0d",
                                          frames_seen, got.wait_after_us,
                                          want.wait_after_us));
            if (got.last_frame !== want.last_frame)
                report_mismatch($sformatf("frame %0d last_frame got %0b want %0b",
                                          frames_seen, got.last_frame, want.last_frame));
        end
        frames_seen++;
    endtask

    // driver: presents the oldest pending item, holds it while full
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_frames(item);
                pending_items.delete(0);
            end
            if (!(push && full))
            begin
                if (pending_items.size() != 0 && !rests(send_steady))
                begin
                    push <= 1'b1;
                    item <= pending_items[0];
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each frame transfer, drives pop with idles and long holds
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
                check_frame(result);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = RECV_HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= !rests(recv_steady);
            end
        end
    end

    // watchdog: no transfer for too long while work is outstanding
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) ||
            (pending_items.size() == 0 && expected_frames.size() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("[lcd_nibble_shift_frame_sequencer] ERROR");
            $finish;
        end
    end

    task automatic queue_item(input logic [2:0] op, input logic [7:0] b,
                              input logic [2:0] row, input logic [7:0] col);
        lnfs_pkg::in_item_t it;
        it.operation  = op;
        it.byte_value = b;
        it.row        = row;
        it.column     = col;
        pending_items.push_back(it);
    endtask

    // random items, count only those that produce frames
    task automatic queue_random(input int count);
        int         valid;
        int         pick;
        logic [2:0] op;
        valid = 0;
        while (valid < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 22)
                op = lnfs_pkg::OP_COMMAND;
            else if (pick < 44)
                op = lnfs_pkg::OP_CHARACTER;
            else if (pick < 62)
                op = lnfs_pkg::OP_CURSOR;
            else if (pick < 82)
                op = lnfs_pkg::OP_CHAR_AT;
            else if (pick < 90)
                op = lnfs_pkg::OP_INIT;
            else
                op = 3'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
            if (op < OP_FIRST_SPARE)
                valid++;
            queue_item(op, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                       8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_frames.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: byte extremes, every row base and wrap, init, spare codes
        queue_item(lnfs_pkg::OP_COMMAND, 8'h00, 3'd0, 8'd0);
        queue_item(lnfs_pkg::OP_COMMAND, 8'hFF, 3'd7, 8'd255);
        queue_item(lnfs_pkg::OP_CHARACTER, 8'h00, 3'd0, 8'd0);
        queue_item(lnfs_pkg::OP_CHARACTER, 8'hFF, 3'd7, 8'd255);
        queue_item(lnfs_pkg::OP_CURSOR, 8'hFF, 3'd0, 8'd0);
        queue_item(lnfs_pkg::OP_CURSOR, 8'h00, 3'd1, 8'd255);
        queue_item(lnfs_pkg::OP_CURSOR, 8'h5A, 3'd2, 8'd64);
        queue_item(lnfs_pkg::OP_CURSOR, 8'hA5, 3'd3, 8'd255);
        queue_item(lnfs_pkg::OP_CURSOR, 8'h00, 3'd4, 8'd44);
        queue_item(lnfs_pkg::OP_CURSOR, 8'h00, 3'd5, 8'd128);
        queue_item(lnfs_pkg::OP_CURSOR, 8'h00, 3'd6, 8'd1);
        queue_item(lnfs_pkg::OP_CURSOR, 8'h00, 3'd7, 8'd200);
        queue_item(lnfs_pkg::OP_CHAR_AT, 8'hFF, 3'd2, 8'd255);
        queue_item(lnfs_pkg::OP_CHAR_AT, 8'h00, 3'd4, 8'd0);
        queue_item(lnfs_pkg::OP_INIT, 8'hFF, 3'd7, 8'd255);
        queue_item(OP_FIRST_SPARE, 8'hFF, 3'd7, 8'd255);
        queue_item(OP_FIRST_SPARE + 3'd1, 8'h00, 3'd0, 8'd0);
        queue_item(OP_LAST_SPARE, 8'h3C, 3'd3, 8'd17);
        queue_item(lnfs_pkg::OP_CHARACTER, 8'hA5, 3'd2, 8'd99);
        wait_drained();

        // random with idling on both sides
        queue_random(45);
        wait_drained();

        // receiver holds off while the sender keeps offering
        send_steady = 1'b1;
        hold_token  = hold_token + 1;
        queue_random(20);
        wait_drained();
        send_steady = 1'b0;

        // stretch with no idling at all
        send_steady = 1'b1;
        recv_steady = 1'b1;
        queue_random(35);
        wait_drained();
        send_steady = 1'b0;
        recv_steady = 1'b0;

        queue_random(35);
        wait_drained();

        // let any stray frame show up before the verdict
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_frames.size() != 0)
            report_mismatch($sformatf("%0d frames never arrived", expected_frames.size()));
        if (error_count == 0)
            $display("[lcd_nibble_shift_frame_sequencer] OK");
        else
            $display("[lcd_nibble_shift_frame_sequencer] ERROR");
        $finish;
    end

endmodule
